// ----- hw/rtl/nfcs_pkg.sv -----
// Shared types, command codes and write scripts for the NOR flash command sequencer.
// Used by every module under hw/rtl; depends on nothing.
package nfcs_pkg;

	// Offset width default and register reset values.
	localparam int unsigned NFCS_OFFSET_BITS = 23;
	localparam logic [19:0] POLL_LIMIT_RESET = 20'd150000;
	localparam logic [31:0] BASE_RESET = 32'h0000_0000;

	// Command codes of an input item.
	localparam logic [2:0] CMD_SECTOR_ERASE = 3'd0;
	localparam logic [2:0] CMD_BLOCK_ERASE = 3'd1;
	localparam logic [2:0] CMD_PROGRAM = 3'd2;
	localparam logic [2:0] CMD_READ_ID = 3'd3;
	localparam logic [2:0] CMD_READ_RESP = 3'd4;

	// Result kinds.
	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_READ = 2'd1;
	localparam logic [1:0] KIND_DONE = 2'd2;

	// Status codes on a done item.
	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_TIMEOUT = 1'b1;

	// Configuration register indexes (byte address 4*i).
	localparam logic REG_POLL_LIMIT = 1'b0;
	localparam logic REG_BASE = 1'b1;

	// Unlock addresses relative to the base, toggle bit position.
	localparam logic [31:0] ADDR_UNLOCK_A = 32'h0000_aaaa;
	localparam logic [31:0] ADDR_UNLOCK_B = 32'h0000_5554;
	localparam logic [31:0] ADDR_ID_HIGH = 32'h0000_0002;
	localparam int unsigned TOGGLE_BIT = 6;

	typedef struct packed {
		logic [2:0]  command;
		logic [22:0] flash_offset;
		logic [15:0] write_word;
		logic [15:0] read_word;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] bus_address;
		logic [15:0] bus_data;
		logic        status;
		logic [31:0] id_value;
		logic        last;
	} out_item_t;

	// One run of result items.
	typedef enum logic [2:0] {
		SCR_SECTOR,
		SCR_BLOCK,
		SCR_PROGRAM,
		SCR_ID_ENTRY,
		SCR_ID_EXIT,
		SCR_POLL_READ,
		SCR_ID2_READ,
		SCR_DONE
	} script_t;

	// Values a run draws on besides the base address.
	typedef struct packed {
		logic [31:0] addr;
		logic [15:0] wdata;
		logic [31:0] id;
		logic        status;
	} ctx_t;

	// Run request from the controller to the emitter.
	typedef struct packed {
		logic    valid;
		script_t script;
		ctx_t    ctx;
	} start_t;

	// Number of result items in a run.
	function automatic logic [2:0] script_len(script_t scr);
		logic [2:0] n;
		unique case (scr)
			SCR_SECTOR, SCR_BLOCK:    n = 3'd7;
			SCR_PROGRAM:              n = 3'd5;
			SCR_ID_ENTRY, SCR_ID_EXIT: n = 3'd4;
			default:                  n = 3'd1;
		endcase
		return n;
	endfunction

	// Relative address of the unlock writes; step 1 and 4 hit the second address.
	function automatic logic [31:0] unlock_rel(logic [2:0] idx);
		logic [31:0] a;
		if (idx == 3'd1 || idx == 3'd4)
			a = ADDR_UNLOCK_B;
		else
			a = ADDR_UNLOCK_A;
		return a;
	endfunction

	// Data words of the erase scripts, wide form for sector and narrow for block.
	function automatic logic [15:0] erase_data(logic wide, logic [2:0] idx);
		logic [15:0] d;
		unique case (idx)
			3'd0, 3'd3: d = wide ? 16'haaaa : 16'h00aa;
			3'd1, 3'd4: d = wide ? 16'h5555 : 16'h0055;
			3'd2:       d = wide ? 16'h8080 : 16'h0080;
			default:    d = wide ? 16'h3030 : 16'h0050;
		endcase
		return d;
	endfunction

	// Result item at one step of a run.
	function automatic out_item_t script_entry(script_t scr, logic [2:0] idx, ctx_t ctx,
			logic [31:0] base);
		out_item_t r;
		logic [31:0] unlock_addr;
		unlock_addr = base + unlock_rel(idx);
		r = '0;
		r.last = (idx == script_len(scr) - 3'd1);
		unique case (scr)
			SCR_SECTOR, SCR_BLOCK: begin
				if (idx == 3'd6) begin
					r.kind = KIND_READ;
					r.bus_address = ctx.addr;
				end else begin
					r.kind = KIND_WRITE;
					r.bus_address = (idx == 3'd5) ? ctx.addr : unlock_addr;
					r.bus_data = erase_data(scr == SCR_SECTOR, idx);
				end
			end
			SCR_PROGRAM: begin
				unique case (idx)
					3'd0: begin
						r.bus_address = unlock_addr;
						r.bus_data = 16'haaaa;
					end
					3'd1: begin
						r.bus_address = unlock_addr;
						r.bus_data = 16'h5555;
					end
					3'd2: begin
						r.bus_address = unlock_addr;
						r.bus_data = 16'ha0a0;
					end
					3'd3: begin
						r.bus_address = ctx.addr;
						r.bus_data = ctx.wdata;
					end
					default: begin
						r.kind = KIND_READ;
						r.bus_address = ctx.addr;
					end
				endcase
			end
			SCR_ID_ENTRY, SCR_ID_EXIT: begin
				if (idx == 3'd3) begin
					if (scr == SCR_ID_ENTRY) begin
						r.kind = KIND_READ;
						r.bus_address = base;
					end else begin
						r.kind = KIND_DONE;
						r.id_value = ctx.id;
					end
				end else begin
					r.kind = KIND_WRITE;
					r.bus_address = unlock_addr;
					unique case (idx)
						3'd0:    r.bus_data = 16'h00aa;
						3'd1:    r.bus_data = 16'h0055;
						default: r.bus_data = (scr == SCR_ID_ENTRY) ? 16'h0090 : 16'h00f0;
					endcase
				end
			end
			SCR_POLL_READ, SCR_ID2_READ: begin
				r.kind = KIND_READ;
				r.bus_address = ctx.addr;
			end
			default: begin
				r.kind = KIND_DONE;
				r.status = ctx.status;
			end
		endcase
		return r;
	endfunction

endpackage

// ----- hw/rtl/nor_flash_command_sequencer.sv -----
// Top level of the NOR flash command sequencer: input register, decode, run emitter.
// Depends on nfcs_pkg, nfcs_cfg, nfcs_ctrl and nfcs_emit.
//
//  channel  | signals                                  | moves
//  in       | in_valid, in_ready, in_item              | one command or read response item
//  out      | out_valid, out_ready, out_item           | one bus write, read request or done
//  cfg      | psel, penable, pwrite, paddr, pwdata ... | poll limit at 0, base address at 4
//
// An item waits in the input register until it is decoded; its first result then goes
// to the result register. Single-result items sustain one item per cycle while the
// output is not stalled; a run of up to seven results holds the input register, and the
// script sequencer emits one result per cycle while the output is not stalled. Reset
// clears the phase, the polling state and both valid flags. A stalled output holds the
// result register and, through it, the input register.
module nor_flash_command_sequencer import nfcs_pkg::*; #(
	parameter int unsigned OFFSET_BITS = NFCS_OFFSET_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_item,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_item,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic        valid_s1;
	in_item_t    item_s1;
	logic        consume;
	logic        busy;
	logic        out_free;
	logic [19:0] poll_limit;
	logic [31:0] base_address;
	start_t      start;

	// The registered item is decoded once no run is pending and the result register frees.
	assign consume = valid_s1 && !busy && out_free;
	assign in_ready = !valid_s1 || consume;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			item_s1 <= in_item;
	end

	nfcs_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.poll_limit   (poll_limit),
		.base_address (base_address)
	);

	nfcs_ctrl #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_s1      (item_s1),
		.consume      (consume),
		.poll_limit   (poll_limit),
		.base_address (base_address),
		.start        (start)
	);

	nfcs_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.base_address (base_address),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.out_item     (out_item),
		.busy         (busy),
		.out_free     (out_free)
	);

endmodule

// ----- hw/rtl/nfcs_cfg.sv -----
// Configuration registers (poll limit, base address) behind the APB-style port.
// Depends on nfcs_pkg for reset values and register indexes.
module nfcs_cfg import nfcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [19:0] poll_limit,
	output logic [31:0] base_address
);

	logic [19:0] poll_limit_q;
	logic [31:0] base_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;

	// Register writes in the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_limit_q <= POLL_LIMIT_RESET;
			base_q <= BASE_RESET;
		end else if (wr_en) begin
			if (paddr[2] == REG_POLL_LIMIT)
				poll_limit_q <= pwdata[19:0];
			else
				base_q <= pwdata;
		end
	end

	// Read data.
	assign prdata = (paddr[2] == REG_BASE) ? base_q : {12'd0, poll_limit_q};

	assign poll_limit = poll_limit_q;
	assign base_address = base_q;

endmodule

// ----- hw/rtl/nfcs_ctrl.sv -----
// Command decode and polling state: makes a run request of each item the phase accepts.
// Depends on nfcs_pkg for item types, codes and the run request struct.
module nfcs_ctrl import nfcs_pkg::*; #(
	parameter int unsigned OFFSET_BITS = NFCS_OFFSET_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  in_item_t    item_s1,
	input  logic        consume,
	input  logic [19:0] poll_limit,
	input  logic [31:0] base_address,
	output start_t      start
);

	localparam logic [31:0] OFF_MASK = 32'((64'd1 << OFFSET_BITS) - 64'd1);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_POLL_FIRST,
		PH_POLL_NEXT,
		PH_ID_LOW,
		PH_ID_HIGH
	} phase_t;

	phase_t      phase_q, phase_d;
	logic        prev_tog_q, prev_tog_d;
	logic [19:0] poll_cnt_q, poll_cnt_d;
	logic [31:0] poll_addr_q, poll_addr_d;
	logic [15:0] id_low_q, id_low_d;
	logic [19:0] cnt_inc;
	logic [31:0] target;
	logic        tog;

	assign target = base_address + ({9'd0, item_s1.flash_offset} & OFF_MASK);
	assign tog = item_s1.read_word[TOGGLE_BIT];
	assign cnt_inc = poll_cnt_q + 20'd1;

	// Decode the item against the current phase.
	always_comb begin
		phase_d = phase_q;
		prev_tog_d = prev_tog_q;
		poll_cnt_d = poll_cnt_q;
		poll_addr_d = poll_addr_q;
		id_low_d = id_low_q;
		start = '0;
		start.script = SCR_DONE;
		if (item_s1.command <= CMD_READ_ID) begin
			if (phase_q == PH_IDLE) begin
				start.valid = 1'b1;
				start.ctx.addr = target;
				start.ctx.wdata = item_s1.write_word;
				poll_addr_d = target;
				poll_cnt_d = '0;
				phase_d = PH_POLL_FIRST;
				unique case (item_s1.command)
					CMD_SECTOR_ERASE: start.script = SCR_SECTOR;
					CMD_BLOCK_ERASE:  start.script = SCR_BLOCK;
					CMD_PROGRAM:      start.script = SCR_PROGRAM;
					default: begin
						start.script = SCR_ID_ENTRY;
						poll_addr_d = poll_addr_q;
						poll_cnt_d = poll_cnt_q;
						phase_d = PH_ID_LOW;
					end
				endcase
			end
		end else if (item_s1.command == CMD_READ_RESP) begin
			unique case (phase_q)
				PH_POLL_FIRST: begin
					start.valid = 1'b1;
					prev_tog_d = tog;
					poll_cnt_d = '0;
					if (poll_limit == 20'd0) begin
						start.script = SCR_DONE;
						start.ctx.status = STATUS_TIMEOUT;
						phase_d = PH_IDLE;
					end else begin
						start.script = SCR_POLL_READ;
						start.ctx.addr = poll_addr_q;
						phase_d = PH_POLL_NEXT;
					end
				end
				PH_POLL_NEXT: begin
					start.valid = 1'b1;
					if (tog == prev_tog_q) begin
						start.script = SCR_DONE;
						start.ctx.status = STATUS_OK;
						phase_d = PH_IDLE;
					end else begin
						prev_tog_d = tog;
						poll_cnt_d = cnt_inc;
						if (cnt_inc >= poll_limit) begin
							start.script = SCR_DONE;
							start.ctx.status = STATUS_TIMEOUT;
							phase_d = PH_IDLE;
						end else begin
							start.script = SCR_POLL_READ;
							start.ctx.addr = poll_addr_q;
						end
					end
				end
				PH_ID_LOW: begin
					start.valid = 1'b1;
					id_low_d = item_s1.read_word;
					start.script = SCR_ID2_READ;
					start.ctx.addr = base_address + ADDR_ID_HIGH;
					phase_d = PH_ID_HIGH;
				end
				PH_ID_HIGH: begin
					start.valid = 1'b1;
					start.script = SCR_ID_EXIT;
					start.ctx.id = {item_s1.read_word, id_low_q};
					phase_d = PH_IDLE;
				end
				default: phase_d = PH_IDLE;
			endcase
		end
		if (!consume)
			start.valid = 1'b0;
	end

	// Phase and polling state advance when the item leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			prev_tog_q <= 1'b0;
			poll_cnt_q <= '0;
			poll_addr_q <= '0;
			id_low_q <= '0;
		end else if (consume) begin
			phase_q <= phase_d;
			prev_tog_q <= prev_tog_d;
			poll_cnt_q <= poll_cnt_d;
			poll_addr_q <= poll_addr_d;
			id_low_q <= id_low_d;
		end
	end

endmodule

// ----- hw/rtl/nfcs_emit.sv -----
// Run sequencer and result register: emits one result item per cycle from a script while the output is not stalled.
// Depends on nfcs_pkg for the scripts and the result item type.
module nfcs_emit import nfcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  start_t      start,
	input  logic [31:0] base_address,
	input  logic        out_ready,
	output logic        out_valid,
	output out_item_t   out_item,
	output logic        busy,
	output logic        out_free
);

	logic       out_valid_q;
	out_item_t  out_item_q;
	logic       run_act_q;
	logic [2:0] run_idx_q;
	script_t    run_script_q;
	ctx_t       run_ctx_q;
	logic       emit_run;
	logic       emit_new;
	out_item_t  cur;

	assign out_free = !out_valid_q || out_ready;
	assign emit_run = run_act_q && out_free;
	assign emit_new = !run_act_q && start.valid;

	// Next result from the active run, or the first one of a new run.
	always_comb begin
		if (run_act_q)
			cur = script_entry(run_script_q, run_idx_q, run_ctx_q, base_address);
		else
			cur = script_entry(start.script, 3'd0, start.ctx, base_address);
	end

	// Output valid and run progress.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			run_act_q <= 1'b0;
			run_idx_q <= '0;
		end else if (emit_run) begin
			out_valid_q <= 1'b1;
			if (cur.last)
				run_act_q <= 1'b0;
			run_idx_q <= run_idx_q + 3'd1;
		end else if (emit_new) begin
			out_valid_q <= 1'b1;
			run_act_q <= !cur.last;
			run_idx_q <= 3'd1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload and run context.
	always_ff @(posedge clk) begin
		if (emit_run || emit_new)
			out_item_q <= cur;
		if (emit_new) begin
			run_script_q <= start.script;
			run_ctx_q <= start.ctx;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_item_q;
	assign busy = run_act_q;

endmodule
